>>> sv/mxsum_pkg.sv
`default_nettype none

package mxsum_pkg;

    // Widths of the accumulator and the FP32 fields
    localparam int unsigned SUM_W     = 13;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned EXP_W     = 8;
    localparam int unsigned FRAC_W    = 23;
    localparam int unsigned FRAC_BITS = 6;
    localparam int unsigned EXP_INF   = 255;

    // One input request: a block element plus the block scale and end mark
    typedef struct packed {
        logic signed [7:0] element;
        logic [7:0]        blk_scale;
        logic              last;
    } item_t;

    // One FP32 result
    typedef struct packed {
        logic              sign;
        logic [EXP_W-1:0]  exponent;
        logic [FRAC_W-1:0] fraction;
        logic              overflow;
    } result_t;

endpackage

`default_nettype wire

>>> sv/mxint8_block_sum_to_fp32.sv
// MXINT8 block sum to FP32.
// Item channel (item_valid / item_ready / item): one INT8 element per request,
// 1.6 fixed point. Elements add into a 13-bit running sum that wraps on
// overflow. The request with last set adds its element, applies its block
// scale (E8M0) and yields one FP32 result; the sum then clears.
// Requests without last yield no result.
// Result channel (result_valid / result_ready / result): sign, biased
// exponent, fraction and an overflow flag; overflow clamps to infinity.
// A zero sum gives +0, small sums give exact subnormals.
// Path: a last request that is accepted enters the conversion stage; from
// there the converted result loads the output register, which drives
// result_valid, once that register is empty or being taken.
// Throughput: one request per cycle while item_ready is high; the running
// sum and the conversion stage are each registered.
// Reset clears the running sum and all valid flags. When the receiver
// stalls, one converted result waits in the output register and one more
// block sum in the conversion stage; item_ready falls only when both are
// full and result_ready is low, and then no request is taken.
`default_nettype none

module mxint8_block_sum_to_fp32 (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire mxsum_pkg::item_t   item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output mxsum_pkg::result_t      result
);

    localparam int unsigned SW = mxsum_pkg::SUM_W;

    logic                          accept;
    logic                          conv_move;
    logic [SW-1:0]                 sum_reg;
    logic [SW-1:0]                 sum_next;
    logic [SW-1:0]                 sum_add;
    logic                          conv_valid_reg;
    logic                          conv_valid_next;
    logic [SW-1:0]                 conv_sum_reg;
    logic [7:0]                    conv_scale_reg;
    logic                          result_valid_reg;
    logic                          result_valid_next;
    mxsum_pkg::result_t            result_reg;
    mxsum_pkg::result_t            result_next;
    logic                          neg;
    logic [SW-1:0]                 mag;
    logic [mxsum_pkg::LEN_W-1:0]   len;
    logic [mxsum_pkg::LEN_W-1:0]   lz;
    logic signed [9:0]             exp_wide;
    logic [SW+10:0]                norm;
    logic [mxsum_pkg::FRAC_W-1:0]  sub_frac;

    // Take a request when the conversion stage is free or draining
    assign item_ready = !conv_valid_reg || !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;
    assign conv_move  = conv_valid_reg && (!result_valid_reg || result_ready);

    // Accumulate the element; clear after the block's last element
    always_comb
    begin
        sum_add  = sum_reg + {{(SW-8){item.element[7]}}, item.element};
        sum_next = sum_reg;
        if (accept)
        begin
            sum_next = item.last ? '0 : sum_add;
        end
    end

    // Advance the valid flags of both stages
    always_comb
    begin
        conv_valid_next = conv_valid_reg;
        if (accept && item.last)
        begin
            conv_valid_next = 1'b1;
        end
        else if (conv_move)
        begin
            conv_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (conv_move)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Magnitude, its bit length, the biased exponent and the aligned fractions
    always_comb
    begin
        neg = conv_sum_reg[SW-1];
        mag = neg ? (~conv_sum_reg + 1'b1) : conv_sum_reg;
        len = '0;
        for (int i = 0; i < SW; i++)
        begin
            if (mag[i])
            begin
                len = mxsum_pkg::LEN_W'(i + 1);
            end
        end
        lz       = mxsum_pkg::LEN_W'(SW) - len;
        exp_wide = $signed({2'b00, conv_scale_reg}) + $signed({6'b0, len})
                 - $signed(10'(mxsum_pkg::FRAC_BITS + 1));
        norm     = {mag, 11'b0} << lz;
        sub_frac = {10'b0, mag} << (5'd16 + {2'b00, conv_scale_reg[2:0]});
    end

    // Build the FP32 fields: zero, subnormal, normal or infinity
    always_comb
    begin
        result_next.sign     = neg;
        result_next.exponent = '0;
        result_next.fraction = '0;
        result_next.overflow = 1'b0;
        if (mag == '0)
        begin
            result_next.sign = 1'b0;
        end
        else if (exp_wide <= 10'sd0)
        begin
            result_next.fraction = sub_frac;
        end
        else if (exp_wide >= $signed(10'(mxsum_pkg::EXP_INF)))
        begin
            result_next.exponent = mxsum_pkg::EXP_W'(mxsum_pkg::EXP_INF);
            result_next.overflow = 1'b1;
        end
        else
        begin
            result_next.exponent = exp_wide[7:0];
            result_next.fraction = norm[mxsum_pkg::FRAC_W-1:0];
        end
    end

    // Hold control state; load payload stages on their handshakes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg          <= '0;
            conv_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg          <= sum_next;
            conv_valid_reg   <= conv_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.last)
        begin
            conv_sum_reg   <= sum_add;
            conv_scale_reg <= item.blk_scale;
        end
        if (conv_move)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> sv/mxsum_checker.sv
`default_nettype none

module mxsum_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_ready,
    input wire mxsum_pkg::item_t   item,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire mxsum_pkg::result_t result
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Infinity carries the overflow flag and nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow |->
            result.exponent == 8'hFF && result.fraction == '0)
        else $error("overflow result is not infinity");

    // Zero is always positive and carries no overflow flag
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.exponent == '0 && result.fraction == '0 |->
            !result.sign && !result.overflow)
        else $error("negative or flagged zero");

    // A fresh result follows an accepted last request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready && item.last, 2))
        else $error("result without a last request");

endmodule

bind mxint8_block_sum_to_fp32 mxsum_checker u_mxsum_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

>>> tb/mxint8_block_sum_to_fp32_test.sv
`timescale 1ns / 1ps

module mxint8_block_sum_to_fp32_test;
    import mxsum_pkg::*;

    localparam int BLOCK_LEN    = 32;
    localparam int RANDOM_ITEMS = 1680;
    localparam int WATCHDOG     = 1000;
    localparam int DIR_ROWS     = 25;

    // One row of the directed table: request plus an optional hand-typed answer
    typedef struct packed {
        item_t   req;
        logic    typed;
        result_t want;
    } vector_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    // Hand-typed answer that travels alongside the current request
    logic    row_typed;
    result_t row_want;

    result_t     fp32_q[$];
    logic [12:0] block_sum;
    int          errors;
    int          idle_cycles;
    int          burst_left;
    int unsigned stall_age;
    logic [15:0] stall_pat;

    vector_t dir_tab [0:DIR_ROWS-1];

    mxint8_block_sum_to_fp32 DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Convert a 13-bit block sum with an E8M0 scale to FP32 fields
    function automatic result_t to_fp32(input logic [12:0] acc, input logic [7:0] scale);
        result_t r;
        int      s;
        int      mag;
        int      len;
        int      e;
        r = '0;
        s = int'(signed'(acc));
        mag = (s < 0) ? -s : s;
        len = 0;
        while ((mag >> len) != 0)
            len++;
        if (mag != 0)
        begin
            r.sign = (s < 0);
            e = int'(scale) - int'(FRAC_BITS) + len - 1;
            if (e <= 0)
                r.fraction = FRAC_W'(mag << (int'(scale) + 16));
            else if (e < int'(EXP_INF))
            begin
                r.exponent = EXP_W'(e);
                r.fraction = FRAC_W'(mag << (24 - len));
            end
            else
            begin
                r.exponent = EXP_W'(EXP_INF);
                r.overflow = 1'b1;
            end
        end
        return r;
    endfunction

    // Check results against the oldest pending FP32, predict on each accepted last request, watch for a hang
    always @(posedge clk)
    begin
        result_t want;
        logic    progress;
        if (rst_n)
        begin
            progress = 1'b0;
            if (result_valid && result_ready)
            begin
                progress = 1'b1;
                if (fp32_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected none, actual sign %0d exp %0d frac %h ovf %0d",
                             $time, result.sign, result.exponent, result.fraction,
                             result.overflow);
                end
                else
                begin
                    want = fp32_q.pop_front();
                    if (result.sign !== want.sign || result.exponent !== want.exponent ||
                        result.fraction !== want.fraction || result.overflow !== want.overflow)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected sign %0d exp %0d frac %h ovf %0d",
                                 $time, want.sign, want.exponent, want.fraction, want.overflow);
                        $display("%0t:           actual sign %0d exp %0d frac %h ovf %0d",
                                 $time, result.sign, result.exponent, result.fraction,
                                 result.overflow);
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                progress = 1'b1;
                block_sum = block_sum + {{5{item.element[7]}}, item.element};
                if (item.last)
                begin
                    want = to_fp32(block_sum, item.blk_scale);
                    if (row_typed)
                        want = row_want;
                    fp32_q.push_back(want);
                    block_sum = '0;
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stall the receiver on a rotating pattern, reloaded now and then
    always @(posedge clk)
    begin
        if (stall_age == 0)
        begin
            stall_age = $urandom_range(40, 400);
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
        stall_age--;
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        result_ready <= stall_pat[0];
    end

    // Hold one request on the bus until it is accepted
    task automatic send_req(input item_t r, input logic typed, input result_t w);
        item       <= r;
        row_typed  <= typed;
        row_want   <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // Send in bursts, drop valid for a random gap between them
    task automatic pace;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Hold off until every pending FP32 has come back
    task automatic drain;
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (fp32_q.size() != 0);
    endtask

    initial
    begin
        item_t       req;
        logic [7:0]  el;
        logic [7:0]  pile;
        int          sent;
        int          blk_len;
        int          flavor;
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        row_typed    = 1'b0;
        row_want     = '0;
        block_sum    = '0;
        errors       = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        stall_age    = 0;
        stall_pat    = 16'hFFFF;

        // Directed rows: zero, unit values, extremes, overflow, subnormals, cancellation
        dir_tab = '{
            '{'{ 8'sd0,    8'd127, 1'b1}, 1'b1, '{1'b0, 8'd0,   23'h000000, 1'b0}},
            '{'{ 8'sd64,   8'd127, 1'b1}, 1'b1, '{1'b0, 8'd127, 23'h000000, 1'b0}},
            '{'{-8'sd64,   8'd127, 1'b1}, 1'b1, '{1'b1, 8'd127, 23'h000000, 1'b0}},
            '{'{-8'sd128,  8'd127, 1'b1}, 1'b1, '{1'b1, 8'd128, 23'h000000, 1'b0}},
            '{'{ 8'sd127,  8'd127, 1'b1}, 1'b0, '0},
            '{'{ 8'sd127,  8'd255, 1'b1}, 1'b1, '{1'b0, 8'd255, 23'h000000, 1'b1}},
            '{'{-8'sd128,  8'd255, 1'b1}, 1'b1, '{1'b1, 8'd255, 23'h000000, 1'b1}},
            '{'{ 8'sd64,   8'd255, 1'b1}, 1'b0, '0},
            '{'{ 8'sd1,    8'd255, 1'b1}, 1'b0, '0},
            '{'{ 8'sd1,    8'd0,   1'b1}, 1'b1, '{1'b0, 8'd0,   23'h010000, 1'b0}},
            '{'{-8'sd1,    8'd0,   1'b1}, 1'b1, '{1'b1, 8'd0,   23'h010000, 1'b0}},
            '{'{ 8'sd127,  8'd0,   1'b1}, 1'b0, '0},
            '{'{ 8'sd1,    8'd6,   1'b1}, 1'b0, '0},
            '{'{ 8'sd1,    8'd7,   1'b1}, 1'b0, '0},
            '{'{ 8'sd100,  8'd255, 1'b0}, 1'b0, '0},
            '{'{-8'sd100,  8'd0,   1'b0}, 1'b0, '0},
            '{'{ 8'sd0,    8'd200, 1'b1}, 1'b1, '{1'b0, 8'd0,   23'h000000, 1'b0}},
            '{'{ 8'sd127,  8'd255, 1'b0}, 1'b0, '0},
            '{'{ 8'sd127,  8'd0,   1'b0}, 1'b0, '0},
            '{'{ 8'sd127,  8'd127, 1'b1}, 1'b0, '0},
            '{'{-8'sd128,  8'd0,   1'b0}, 1'b0, '0},
            '{'{-8'sd128,  8'd0,   1'b0}, 1'b0, '0},
            '{'{-8'sd128,  8'd130, 1'b1}, 1'b0, '0},
            '{'{-8'sd1,    8'd85,  1'b0}, 1'b0, '0},
            '{'{ 8'sd1,    8'd170, 1'b1}, 1'b1, '{1'b0, 8'd0,   23'h000000, 1'b0}}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            pace;
            send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
        end
        drain;

        // Random blocks: mostly nominal length, some long enough to wrap the sum
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(BLOCK_LEN + 1, 80)
                                                  : $urandom_range(1, BLOCK_LEN);
            flavor = $urandom_range(0, 3);
            pile = $urandom_range(0, 1) ? 8'h7F : 8'h80;
            for (int k = 0; k < blk_len; k++)
            begin
                case (flavor)
                    0:       el = 8'($urandom);
                    1:       el = pile;
                    2:       el = 8'($urandom_range(0, 6)) - 8'd3;
                    default: el = (k == 0) ? 8'($urandom) : 8'h00;
                endcase
                req.element = el;
                case ($urandom_range(0, 3))
                    0:       req.blk_scale = 8'($urandom);
                    1:       req.blk_scale = 8'($urandom_range(0, 8));
                    2:       req.blk_scale = 8'($urandom_range(245, 255));
                    default: req.blk_scale = 8'($urandom_range(118, 136));
                endcase
                req.last = (k == blk_len - 1);
                pace;
                send_req(req, 1'b0, '0);
                sent++;
                if (sent == RANDOM_ITEMS / 2)
                    drain;
            end
        end

        // Let the pipeline empty, then keep watching for stray results
        drain;
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
